// ===== src/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants of the point-in-polygon test core
// Coordinate and product widths, the request carried from the front to the
// back, the per-edge result and the position codes.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [1:0] POS_OUT = 2'd0;
  localparam logic [1:0] POS_ON  = 2'd1;
  localparam logic [1:0] POS_IN  = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  // One accepted vertex with everything the back needs for its edges.
  typedef struct packed {
    logic   start;
    logic   last;
    coord_t qx;
    coord_t qy;
    coord_t px;
    coord_t py;
    coord_t vx;
    coord_t vy;
    coord_t fx;
    coord_t fy;
  } pip_item_t;

  typedef struct packed {
    logic toggle;
    logic on_edge;
  } edge_res_t;

  function automatic diff_t coord_diff(coord_t a, coord_t b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

endpackage

// ===== src/pip_front.sv =====
// ----------------------------------------------------------------------------
// pip_front: input side of the point-in-polygon test core
// Latches the query point and first vertex, tracks the previous vertex and
// turns each accepted vertex into one request for the back.
// ----------------------------------------------------------------------------
module pip_front import pip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  coord_t    in_query_x,
  input  coord_t    in_query_y,
  input  coord_t    in_vertex_x,
  input  coord_t    in_vertex_y,
  input  logic      in_last_vertex,
  input  logic      fifo_full,
  output logic      push,
  output pip_item_t item
);

  logic   mid_r;
  coord_t first_x_r, first_y_r, prev_x_r, prev_y_r, held_qx_r, held_qy_r;

  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;

  // On the first vertex the query and first vertex come straight from the ports.
  always_comb begin
    item.start = !mid_r;
    item.last  = in_last_vertex;
    item.qx    = mid_r ? held_qx_r : in_query_x;
    item.qy    = mid_r ? held_qy_r : in_query_y;
    item.px    = prev_x_r;
    item.py    = prev_y_r;
    item.vx    = in_vertex_x;
    item.vy    = in_vertex_y;
    item.fx    = mid_r ? first_x_r : in_vertex_x;
    item.fy    = mid_r ? first_y_r : in_vertex_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
    end else if (push) begin
      mid_r <= !in_last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      prev_x_r <= in_vertex_x;
      prev_y_r <= in_vertex_y;
      if (!mid_r) begin
        held_qx_r <= in_query_x;
        held_qy_r <= in_query_y;
        first_x_r <= in_vertex_x;
        first_y_r <= in_vertex_y;
      end
    end
  end

endmodule

// ===== src/pip_fifo.sv =====
// ----------------------------------------------------------------------------
// pip_fifo: request queue between front and back
// A small register-file queue that lets the front keep accepting vertices
// while the back waits on the result channel.
// ----------------------------------------------------------------------------
module pip_fifo import pip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pip_item_t wr_item,
  input  logic      pop,
  output pip_item_t rd_item,
  output logic      empty,
  output logic      full
);

  pip_item_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r, count_nxt;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign rd_item = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== src/pip_edge.sv =====
// ----------------------------------------------------------------------------
// pip_edge: exact crossing and boundary test for one polygon edge
// Registers the four products of the edge vectors, then forms the cross and
// dot products and decides parity toggle and on-edge.
// ----------------------------------------------------------------------------
module pip_edge import pip_pkg::*; (
  input  logic      clk,
  input  logic      adv,
  input  diff_t     ax,
  input  diff_t     ay,
  input  diff_t     bx,
  input  diff_t     by,
  output edge_res_t res
);

  prod_t cr_l_r, cr_r_r, dot_l_r, dot_r_r;
  logic  ay_le0_r, ay_gt0_r, by_le0_r, by_gt0_r;
  sum_t  cr_sum, dot;
  logic  cr_neg, cr_zero, cr_pos, dot_le0;

  always_ff @(posedge clk) begin
    if (adv) begin
      cr_l_r   <= ax * by;
      cr_r_r   <= ay * bx;
      dot_l_r  <= ax * bx;
      dot_r_r  <= ay * by;
      ay_le0_r <= ay[DIFF_W-1] || (ay == '0);
      ay_gt0_r <= !(ay[DIFF_W-1] || (ay == '0));
      by_le0_r <= by[DIFF_W-1] || (by == '0);
      by_gt0_r <= !(by[DIFF_W-1] || (by == '0));
    end
  end

  always_comb begin
    cr_sum  = SUM_W'(cr_l_r) - SUM_W'(cr_r_r);
    dot     = SUM_W'(dot_l_r) + SUM_W'(dot_r_r);
    cr_neg  = cr_sum[SUM_W-1];
    cr_zero = (cr_sum == '0);
    cr_pos  = !cr_neg && !cr_zero;
    dot_le0 = dot[SUM_W-1] || (dot == '0);
    // An edge going downward swaps its ends, which flips the cross sign.
    res.toggle  = (ay_le0_r && by_gt0_r && cr_neg) || (by_le0_r && ay_gt0_r && cr_pos);
    res.on_edge = cr_zero && dot_le0;
  end

endmodule

// ===== src/pip_back.sv =====
// ----------------------------------------------------------------------------
// pip_back: edge evaluation and result side of the point-in-polygon core
// Pops requests, forms the edge vectors, runs the incoming and closing edges
// each in its own edge unit and keeps parity, boundary flag and the result register.
// ----------------------------------------------------------------------------
module pip_back import pip_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fifo_empty,
  input  pip_item_t  item,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_position
);

  logic      adv;
  logic      a_v_r, a_start_r, a_last_r;
  logic      b_v_r, b_start_r, b_last_r;
  diff_t     dpx_r, dpy_r, dvx_r, dvy_r, dfx_r, dfy_r;
  logic      parity_r, bound_r, parity_nxt, bound_nxt;
  logic      out_valid_r;
  logic [1:0] out_pos_r, pos_nxt;
  edge_res_t res_in, res_close;

  // The whole back moves as one pipeline whenever the result register is free.
  assign adv          = !out_valid_r || !out_stall;
  assign pop          = adv && !fifo_empty;
  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;

  pip_edge u_edge_in (
    .clk (clk),
    .adv (adv),
    .ax  (dpx_r),
    .ay  (dpy_r),
    .bx  (dvx_r),
    .by  (dvy_r),
    .res (res_in)
  );

  pip_edge u_edge_close (
    .clk (clk),
    .adv (adv),
    .ax  (dvx_r),
    .ay  (dvy_r),
    .bx  (dfx_r),
    .by  (dfy_r),
    .res (res_close)
  );

  // The first vertex of a polygon has no incoming edge and restarts the flags.
  always_comb begin
    parity_nxt = b_start_r ? 1'b0 : parity_r;
    bound_nxt  = b_start_r ? 1'b0 : bound_r;
    if (!b_start_r) begin
      parity_nxt = parity_nxt ^ res_in.toggle;
      bound_nxt  = bound_nxt | res_in.on_edge;
    end
    if (b_last_r) begin
      parity_nxt = parity_nxt ^ res_close.toggle;
      bound_nxt  = bound_nxt | res_close.on_edge;
    end
    pos_nxt = bound_nxt ? POS_ON : (parity_nxt ? POS_IN : POS_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      parity_r    <= 1'b0;
      bound_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_v_r       <= !fifo_empty;
      b_v_r       <= a_v_r;
      out_valid_r <= b_v_r && b_last_r;
      if (b_v_r) begin
        parity_r <= parity_nxt;
        bound_r  <= bound_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_start_r <= item.start;
      a_last_r  <= item.last;
      dpx_r     <= coord_diff(item.px, item.qx);
      dpy_r     <= coord_diff(item.py, item.qy);
      dvx_r     <= coord_diff(item.vx, item.qx);
      dvy_r     <= coord_diff(item.vy, item.qy);
      dfx_r     <= coord_diff(item.fx, item.qx);
      dfy_r     <= coord_diff(item.fy, item.qy);
      b_start_r <= a_start_r;
      b_last_r  <= a_last_r;
      out_pos_r <= pos_nxt;
    end
  end

endmodule

// ===== src/point_in_polygon_test_core.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test_core: crossing-number point-in-polygon classifier
// Vertices stream in one per request; the last vertex closes the polygon
// and yields OUT, ON or IN for the query point latched on the first vertex.
//
//   Channel  Ports                                   Direction  Per request
//   in       in_valid/in_stall, in_query_*,          input      one vertex
//            in_vertex_*, in_last_vertex
//   out      out_valid/out_stall, out_position       output     one result
//
// One vertex per cycle is accepted while in_stall is low; each vertex passes
// through the request queue and then the pipeline stages (edge vectors,
// products, sign test) before the result of a last vertex is registered.
// Reset is synchronous on rst_n and empties the queue and pipeline.
// While out_stall holds the result, the four-entry request queue keeps
// taking vertices; in_stall rises only once that queue is full.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core import pip_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  coord_t     in_query_x,
  input  coord_t     in_query_y,
  input  coord_t     in_vertex_x,
  input  coord_t     in_vertex_y,
  input  logic       in_last_vertex,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_position
);

  pip_item_t wr_item, rd_item;
  logic      push, pop, fifo_empty, fifo_full;

  pip_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_query_x     (in_query_x),
    .in_query_y     (in_query_y),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_last_vertex (in_last_vertex),
    .fifo_full      (fifo_full),
    .push           (push),
    .item           (wr_item)
  );

  pip_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .empty   (fifo_empty),
    .full    (fifo_full)
  );

  pip_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .fifo_empty   (fifo_empty),
    .item         (rd_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_position (out_position)
  );

endmodule

// ===== src/pip_checker.sv =====
// ----------------------------------------------------------------------------
// pip_checker: port-level checks for the point-in-polygon test core
// Tracks polygons closed but not yet answered and checks results and
// stalls against them.
// ----------------------------------------------------------------------------
module pip_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last_vertex,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_position
);

  logic [3:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(in_valid && !in_stall && in_last_vertex)
                       - 4'(out_valid && !out_stall);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_position))
    else $error("stalled result changed or dropped");

  a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result given without a closed polygon");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd7)
    else $error("more polygons in flight than the queue and pipeline hold");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled while the result side was moving");

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last_vertex (in_last_vertex),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_position   (out_position)
);

// ===== bench/pip_position_checker.sv =====
// ----------------------------------------------------------------------------
// pip_position_checker: predicts and checks point-in-polygon positions
// Watches the vertex and result channels of the core, keeps its own copy of
// the polygon state, works out the position of the query point on every
// closing vertex and compares each accepted result against the oldest one.
// ----------------------------------------------------------------------------
module pip_position_checker import pip_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  coord_t     in_query_x,
  input  coord_t     in_query_y,
  input  coord_t     in_vertex_x,
  input  coord_t     in_vertex_y,
  input  logic       in_last_vertex,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_position,
  output int         mismatch_count,
  output int         positions_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  coord_t     start_x, start_y, last_x, last_y, query_x, query_y;
  logic       crossings_odd, touches_edge, in_polygon;
  logic [1:0] expected_positions[$];
  int         failures = 0;
  int         pending_count = 0;

  assign mismatch_count    = failures;
  assign positions_pending = pending_count;

  // Crossing and boundary test of one edge against the held query point.
  function automatic edge_res_t test_edge(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    longint    ax, ay, bx, by, t, cr, dot;
    edge_res_t r;
    ax = longint'(sx) - longint'(query_x);
    ay = longint'(sy) - longint'(query_y);
    bx = longint'(ex) - longint'(query_x);
    by = longint'(ey) - longint'(query_y);
    // Orient the edge upward so the sign of the cross product is meaningful.
    if (ay > by) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    cr        = ax * by - ay * bx;
    dot       = ax * bx + ay * by;
    r.toggle  = (ay <= 0) && (by > 0) && (cr < 0);
    r.on_edge = (cr == 0) && (dot <= 0);
    return r;
  endfunction

  always @(posedge clk) begin
    edge_res_t  r;
    logic [1:0] want;
    if (!rst_n) begin
      start_x = '0; start_y = '0; last_x = '0; last_y = '0;
      query_x = '0; query_y = '0;
      crossings_odd = 1'b0;
      touches_edge  = 1'b0;
      in_polygon    = 1'b0;
      expected_positions.delete();
      pending_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_positions.size() == 0) begin
          $error("position: expected none, actual %0d", out_position);
          failures <= failures + 1;
        end else begin
          want = expected_positions.pop_front();
          if (out_position !== want) begin
            $error("position: expected %0d, actual %0d", want, out_position);
            failures <= failures + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (!in_polygon) begin
          query_x       = in_query_x;
          query_y       = in_query_y;
          start_x       = in_vertex_x;
          start_y       = in_vertex_y;
          crossings_odd = 1'b0;
          touches_edge  = 1'b0;
          in_polygon    = 1'b1;
        end else begin
          r = test_edge(last_x, last_y, in_vertex_x, in_vertex_y);
          crossings_odd ^= r.toggle;
          touches_edge  |= r.on_edge;
        end
        last_x = in_vertex_x;
        last_y = in_vertex_y;
        if (in_last_vertex) begin
          r = test_edge(in_vertex_x, in_vertex_y, start_x, start_y);
          crossings_odd ^= r.toggle;
          touches_edge  |= r.on_edge;
          want = touches_edge ? POS_ON : (crossings_odd ? POS_IN : POS_OUT);
          expected_positions.insert(expected_positions.size(), want);
          in_polygon = 1'b0;
        end
      end
      pending_count <= expected_positions.size();
    end
  end

endmodule

// ===== bench/point_in_polygon_test_core_tb.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test_core_tb: stimulus and verdict for the polygon core
// Streams directed polygons (single vertex, segment, extreme square, repeated
// vertices, query on edges and vertices), then random polygons of several
// shapes with random idling on both channels, while the checker beside the
// core predicts and compares every position.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core_tb import pip_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  coord_t     in_query_x = '0;
  coord_t     in_query_y = '0;
  coord_t     in_vertex_x = '0;
  coord_t     in_vertex_y = '0;
  logic       in_last_vertex = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_position;
  int         mismatch_count;
  int         positions_pending;

  int idle_pct = 20;
  int rx_hold = 0;
  int accepted = 0;
  int poly_x[$];
  int poly_y[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  point_in_polygon_test_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_query_x     (in_query_x),
    .in_query_y     (in_query_y),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_position   (out_position)
  );

  pip_position_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_query_x        (in_query_x),
    .in_query_y        (in_query_y),
    .in_vertex_x       (in_vertex_x),
    .in_vertex_y       (in_vertex_y),
    .in_last_vertex    (in_last_vertex),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_position      (out_position),
    .mismatch_count    (mismatch_count),
    .positions_pending (positions_pending)
  );

  // Result-side stalls come in bursts of random length while idle_pct is nonzero.
  always @(posedge clk) begin
    if (rx_hold != 0 && idle_pct != 0) begin
      out_stall <= 1'b1;
      rx_hold   <= rx_hold - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
      out_stall <= 1'b1;
      rx_hold   <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
      rx_hold   <= 0;
    end
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int rand_in(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic push_vertex(input int qx, input int qy, input int vx, input int vy,
                             input logic last);
    in_valid       <= 1'b1;
    in_query_x     <= coord_t'(qx);
    in_query_y     <= coord_t'(qy);
    in_vertex_x    <= coord_t'(vx);
    in_vertex_y    <= coord_t'(vy);
    in_last_vertex <= last;
    do @(posedge clk); while (in_stall);
    accepted++;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Query fields of later vertices carry noise; the core must ignore them.
  task automatic send_polygon(input int qx, input int qy);
    int n;
    n = poly_x.size();
    push_vertex(qx, qy, poly_x[0], poly_y[0], n == 1);
    for (int i = 1; i < n; i++)
      push_vertex(rand_in(-32768, 32767), rand_in(-32768, 32767), poly_x[i], poly_y[i],
                  i == n - 1);
  endtask

  task automatic random_polygon();
    int kind, n, cx, cy, span, j, k, qx, qy, x0, x1, y0, y1;
    kind = $urandom_range(0, 9);
    n    = (kind == 9) ? rand_in(9, 24) : rand_in(1, 8);
    cx   = rand_in(-32600, 32600);
    cy   = rand_in(-32600, 32600);
    poly_x.delete();
    poly_y.delete();
    if (kind == 7 || kind == 8) begin
      for (int i = 0; i < n; i++) begin
        poly_x.insert(poly_x.size(), rand_in(-32768, 32767));
        poly_y.insert(poly_y.size(), rand_in(-32768, 32767));
      end
      qx = rand_in(-32768, 32767);
      qy = rand_in(-32768, 32767);
    end else if (kind == 4 || kind == 5) begin
      x0 = cx - rand_in(0, 6);
      x1 = cx + rand_in(1, 6);
      y0 = cy - rand_in(0, 6);
      y1 = cy + rand_in(1, 6);
      if ($urandom_range(0, 1)) begin
        poly_x = '{x0, x1, x1, x0};
        poly_y = '{y0, y0, y1, y1};
      end else begin
        poly_x = '{x0, x0, x1, x1};
        poly_y = '{y0, y1, y1, y0};
      end
      qx = rand_in(x0 - 2, x1 + 2);
      qy = rand_in(y0 - 2, y1 + 2);
    end else begin
      // Even offsets keep edge midpoints on the integer grid.
      span = (kind == 6) ? 40 : 4;
      for (int i = 0; i < n; i++) begin
        poly_x.insert(poly_x.size(), cx + 2 * rand_in(-span, span));
        poly_y.insert(poly_y.size(), cy + 2 * rand_in(-span, span));
      end
      j = rand_in(0, n - 1);
      k = (j + 1) % n;
      case ($urandom_range(0, 2))
        0: begin
          qx = poly_x[j];
          qy = poly_y[j];
        end
        1: begin
          qx = (poly_x[j] + poly_x[k]) / 2;
          qy = (poly_y[j] + poly_y[k]) / 2;
        end
        default: begin
          qx = cx + rand_in(-2 * span, 2 * span);
          qy = cy + rand_in(-2 * span, 2 * span);
        end
      endcase
    end
    send_polygon(qx, qy);
  endtask

  initial begin
    int polygons;
    polygons = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single vertex, on and off the query point.
    poly_x = '{5};
    poly_y = '{-7};
    send_polygon(5, -7);
    send_polygon(6, -7);
    // Full-range square, query strictly inside and then on its right edge.
    poly_x = '{-32768, 32767, 32767, -32768};
    poly_y = '{-32768, -32768, 32767, 32767};
    send_polygon(0, 0);
    send_polygon(32767, 123);
    // Repeated vertex with the query outside.
    poly_x = '{0, 0, 10, 0};
    poly_y = '{0, 0, 0, 10};
    send_polygon(20, 20);
    // Triangle on the extremes, query at the opposite corner.
    poly_x = '{-32768, 32767, 32767};
    poly_y = '{32767, -32768, 32767};
    send_polygon(-32768, -32768);
    // Two-vertex segment through the query point.
    poly_x = '{-4, 4};
    poly_y = '{-4, 4};
    send_polygon(1, 1);
    // Ray from the query runs along the bottom edge.
    poly_x = '{0, 10, 10, 0};
    poly_y = '{0, 0, 10, 10};
    send_polygon(-5, 0);

    // Hold off until every position of the directed part has come back.
    in_valid <= 1'b0;
    do @(posedge clk); while (positions_pending != 0);

    while (accepted < 650) begin
      if (polygons % 12 == 0) begin
        case ($urandom_range(0, 3))
          0: idle_pct <= 0;
          1: idle_pct <= 5;
          2: idle_pct <= 25;
          default: idle_pct <= 60;
        endcase
      end
      random_polygon();
      polygons++;
    end
    idle_pct <= 0;
    while (accepted < 745) random_polygon();

    in_valid <= 1'b0;
    do @(posedge clk); while (positions_pending != 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== point_in_polygon_test_core.f =====
src/pip_pkg.sv
src/pip_front.sv
src/pip_fifo.sv
src/pip_edge.sv
src/pip_back.sv
src/point_in_polygon_test_core.sv
src/pip_checker.sv
bench/pip_position_checker.sv
bench/point_in_polygon_test_core_tb.sv
